>>> src/bbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_pkg: shared types and constants for the 3x3 box blur stream
// Sizes, register indexes, pipeline metadata and the divide-by-nine constant.
// ----------------------------------------------------------------------------
package bbs_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_SIZE   = 3;

    localparam int PIX_W  = 8;
    localparam int POS_W  = 10;                       // column / row fields
    localparam int SIZE_W = 11;                       // frame size registers
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CSUM_W = PIX_W + 2;                // sum of three pixels
    localparam int WSUM_W = PIX_W + 4;                // sum of nine pixels

    // floor(x / 9) = (x * RECIP_9) >> RECIP_SHIFT for every nine-pixel sum
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_9     = (1 << RECIP_SHIFT) / 9 + 1;
    localparam int RECIP_W     = 13;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic             emit;
        logic             done;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } meta_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] mean;
    } result_t;

endpackage

>>> src/box_blur_3x3_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_stream: streaming 3x3 box filter
// Raster-order 8-bit pixels in, floor(mean of 3x3 neighbourhood) out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one pixel per word; s_tuser marks the first pixel of a frame
//   and resets the position to column 0, row 0. Frames may also follow each
//   other without the mark: the position wraps after the last pixel.
//   m_ channel: one word per interior pixel (border pixels give nothing),
//   carrying the mean, the centre column and row; m_tlast flags the last
//   interior result of the frame.
//   cfg_ port: frame_width (index 0) and frame_height (index 1), both clamped
//   to 3..1024; write only while the stream is idle.
// Timing:
//   One pixel per cycle while s_tready is high; the line store RAM is read
//   once and written once per pixel, with a bypass when a write and a read
//   hit the same column.
// Reset (aresetn low, synchronous): position, window and queue are cleared,
//   sizes go to 1024. Line store contents stay undefined until written.
// Stall: a four-word output queue holds results; s_tready drops once the
//   queue plus the words in flight would fill it.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream
    import bbs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input pixels
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,     // [7:0] pixel_value
    input  logic              s_tuser,     // [0] frame_start
    // results
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,     // [7:0] mean_value, [17:8] center_column,
                                           // [27:18] center_row, [31:28] zero
    output logic              m_tlast,     // frame_done
    // configuration
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [SIZE_W-1:0] cfg_wr_data
);

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [POS_W-1:0]  col_reg, row_reg;
    logic [POS_W-1:0]  col_next, row_next;
    logic [POS_W-1:0]  c_cur, r_cur;
    logic [SIZE_W-1:0] c_inc, r_inc;
    logic              accept;
    meta_t             in_meta;
    meta_t             s1_meta_reg;

    logic              col_valid;
    logic [CSUM_W-1:0] col_sum;
    logic              res_valid;
    logic              s2_busy;
    result_t           res;
    result_t           out_word;
    logic [2:0]        fifo_count;
    logic [2:0]        committed;

    // sizes clamped to the supported range
    always_comb begin
        if (width_reg < SIZE_W'(MIN_SIZE))       w_eff = SIZE_W'(MIN_SIZE);
        else if (width_reg > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
        else                                     w_eff = width_reg;
        if (height_reg < SIZE_W'(MIN_SIZE))       h_eff = SIZE_W'(MIN_SIZE);
        else if (height_reg > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
        else                                       h_eff = height_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_W'(MAX_WIDTH);
            height_reg <= SIZE_W'(MAX_HEIGHT);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_wr_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_wr_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // room left in the queue for every word that could still arrive
    assign committed = fifo_count + {2'b00, col_valid} + {2'b00, s2_busy};
    assign s_tready  = (committed < 3'd4);
    assign accept    = s_tvalid && s_tready;

    // position of the incoming pixel
    assign c_cur = s_tuser ? '0 : col_reg;
    assign r_cur = s_tuser ? '0 : row_reg;
    assign c_inc = SIZE_W'(c_cur) + SIZE_W'(1);
    assign r_inc = SIZE_W'(r_cur) + SIZE_W'(1);

    always_comb begin
        col_next = c_cur;
        row_next = r_cur;
        if (c_inc >= w_eff) begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : r_inc[POS_W-1:0];
        end else begin
            col_next = c_inc[POS_W-1:0];
        end
    end

    assign in_meta.emit = (r_cur >= POS_W'(2)) && (c_cur >= POS_W'(2));
    assign in_meta.done = (c_inc == w_eff) && (r_inc == h_eff);
    assign in_meta.col  = c_cur - POS_W'(1);
    assign in_meta.row  = r_cur - POS_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // metadata rides alongside the line store stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_meta_reg <= in_meta;
        end
    end

    bbs_line_buf u_line_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (accept),
        .req_addr  (c_cur[ADDR_W-1:0]),
        .req_pix   (s_tdata),
        .col_valid (col_valid),
        .col_sum   (col_sum)
    );

    bbs_mean u_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .col_valid (col_valid),
        .col_sum   (col_sum),
        .col_meta  (s1_meta_reg),
        .res_valid (res_valid),
        .s2_busy   (s2_busy),
        .res       (res)
    );

    bbs_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (res_valid),
        .wr_data  (res),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_word),
        .count    (fifo_count)
    );

    assign m_tdata = {4'b0000, out_word.row, out_word.col, out_word.mean};
    assign m_tlast = out_word.done;

endmodule

>>> src/bbs_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_line_buf: two line stores with read-modify-write
// One RAM holds {row r-2, row r-1} per column; gives the column sum.
// ----------------------------------------------------------------------------
module bbs_line_buf
    import bbs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    input  logic [ADDR_W-1:0] req_addr,
    input  logic [PIX_W-1:0]  req_pix,
    output logic              col_valid,
    output logic [CSUM_W-1:0] col_sum
);

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] q_reg;
    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic               byp_hit_reg;
    logic [2*PIX_W-1:0] byp_data_reg;

    logic [2*PIX_W-1:0] line;
    logic [2*PIX_W-1:0] wr_data;

    // entry written at the same edge as the RAM read wins over the stale read data
    assign line    = byp_hit_reg ? byp_data_reg : q_reg;
    assign wr_data = {line[PIX_W-1:0], s1_pix_reg};   // mid moves up, pixel goes in

    assign col_valid = s1_valid_reg;
    assign col_sum   = CSUM_W'(line[2*PIX_W-1:PIX_W]) + CSUM_W'(line[PIX_W-1:0])
                     + CSUM_W'(s1_pix_reg);

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            mem[s1_addr_reg] <= wr_data;
        end
        if (req_valid) begin
            q_reg        <= mem[req_addr];
            byp_data_reg <= wr_data;
            s1_addr_reg  <= req_addr;
            s1_pix_reg   <= req_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= req_valid;
            if (req_valid) begin
                byp_hit_reg <= s1_valid_reg && (s1_addr_reg == req_addr);
            end
        end
    end

endmodule

>>> src/bbs_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_mean: column window and divide by nine
// Keeps the two previous column sums, adds the new one, scales by 1/9.
// ----------------------------------------------------------------------------
module bbs_mean
    import bbs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              col_valid,
    input  logic [CSUM_W-1:0] col_sum,
    input  meta_t             col_meta,
    output logic              res_valid,
    output logic              s2_busy,
    output result_t           res
);

    logic [CSUM_W-1:0] win0_reg, win1_reg;
    logic              s2_valid_reg;
    logic [WSUM_W-1:0] sum_reg;
    meta_t             meta_reg;

    logic [WSUM_W+RECIP_W-1:0] prod;

    assign prod = (WSUM_W+RECIP_W)'(sum_reg) * (WSUM_W+RECIP_W)'(RECIP_9);

    assign res_valid = s2_valid_reg;
    assign s2_busy   = s2_valid_reg;
    assign res.mean  = prod[RECIP_SHIFT +: PIX_W];
    assign res.col   = meta_reg.col;
    assign res.row   = meta_reg.row;
    assign res.done  = meta_reg.done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win0_reg     <= '0;
            win1_reg     <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= col_valid && col_meta.emit;
            if (col_valid) begin
                win0_reg <= win1_reg;
                win1_reg <= col_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (col_valid) begin
            sum_reg  <= WSUM_W'(win0_reg) + WSUM_W'(win1_reg) + WSUM_W'(col_sum);
            meta_reg <= col_meta;
        end
    end

endmodule

>>> src/bbs_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_out_fifo: four-word result queue
// Absorbs results still in flight when the receiver stalls.
// ----------------------------------------------------------------------------
module bbs_out_fifo
    import bbs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  result_t wr_data,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rd_data,
    output logic [2:0] count
);

    result_t    fifo_mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       rd_en;

    assign rd_valid = (count_reg != 3'd0);
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = fifo_mem[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fifo_mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (rd_en) rd_ptr_reg <= rd_ptr_reg + 2'd1;
            unique case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 3'd1;
                2'b01:   count_reg <= count_reg - 3'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
